// ----- hw/rtl/sacc_pkg.sv -----
// ----------------------------------------------------------------------------
// sacc_pkg
// Shared types, codes and helpers of the clock-replacement cache tag store.
// ----------------------------------------------------------------------------
package sacc_pkg;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;
  localparam logic [1:0] KIND_OTHER  = 2'd3;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS       = 2'd2;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] address;
  } in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        last;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;
  } out_t;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [5:0] block_bits;
    logic [3:0] ways;
  } cfg_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

// ----- hw/rtl/sacc_fifo.sv -----
// ----------------------------------------------------------------------------
// sacc_fifo
// Small synchronous queue that decouples the two sides of a stage.
// ----------------------------------------------------------------------------
module sacc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- hw/rtl/sacc_front.sv -----
// ----------------------------------------------------------------------------
// sacc_front
// Accepts accesses, splits the address into set and tag, and queues lookups.
// ----------------------------------------------------------------------------
module sacc_front #(
  parameter int MAX_SET_BITS = 5,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  sacc_pkg::cfg_t                          cfg,
  input  logic                                    push,
  input  sacc_pkg::in_t                           in_data,
  output logic                                    full,
  output logic                                    op_valid,
  output logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1) + ADDR_WIDTH:0] op_data,
  input  logic                                    op_pop
);

  localparam int SW        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int OP_W      = 1 + SW + ADDR_WIDTH;
  localparam int OPQ_DEPTH = 2;

  logic [ADDR_WIDTH-1:0] addr;
  logic [ADDR_WIDTH-1:0] set_full;
  logic [ADDR_WIDTH-1:0] tag;
  logic [3:0]            sb;
  logic [6:0]            shift;
  logic [SW-1:0]         set_mask;
  logic [SW-1:0]         set_idx;
  logic                  is_mod;
  logic                  q_push;
  logic                  q_empty;

  assign addr   = in_data.address[ADDR_WIDTH-1:0];
  assign sb     = ({1'b0, cfg.set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                            : {1'b0, cfg.set_bits};
  assign shift  = 7'(cfg.block_bits) + 7'(sb);
  assign set_full = addr >> cfg.block_bits;
  assign tag    = addr >> shift;
  assign is_mod = (in_data.kind == sacc_pkg::KIND_MODIFY);

  always_comb begin
    for (int i = 0; i < SW; i++) begin
      set_mask[i] = (4'(i) < sb);
    end
  end

  assign set_idx  = set_full[SW-1:0] & set_mask;
  assign q_push   = push && !full && (in_data.kind != sacc_pkg::KIND_OTHER);
  assign op_valid = !q_empty;

  sacc_fifo #(
    .WIDTH (OP_W),
    .DEPTH (OPQ_DEPTH)
  ) u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data ({is_mod, set_idx, tag}),
    .full    (full),
    .rd_en   (op_pop),
    .rd_data (op_data),
    .empty   (q_empty)
  );

endmodule

// ----- hw/rtl/sacc_back.sv -----
// ----------------------------------------------------------------------------
// sacc_back
// Lookup engine: reads a set row, compares tags, walks the clock hand on a
// miss, writes the row back and emits one result beat per lookup.
// ----------------------------------------------------------------------------
module sacc_back #(
  parameter int MAX_SET_BITS = 5,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  sacc_pkg::cfg_t                          cfg,
  input  logic                                    op_valid,
  input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1) + ADDR_WIDTH:0] op_data,
  output logic                                    op_pop,
  input  logic                                    res_full,
  output logic                                    res_push,
  output sacc_pkg::out_t                          res_data
);

  localparam int SW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SETS = 1 << MAX_SET_BITS;
  localparam int HW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int OP_W = 1 + SW + ADDR_WIDTH;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  logic [MAX_WAYS-1:0]                  vld_mem  [SETS];
  logic [MAX_WAYS-1:0]                  used_mem [SETS];
  logic [HW-1:0]                        hand_mem [SETS];
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag_mem  [SETS];

  state_t                              state_r, state_nxt;
  logic [SW-1:0]                       clr_r, clr_nxt;
  logic                                dbl_r, dbl_nxt;
  logic [31:0]                         hit_r, hit_nxt;
  logic [31:0]                         miss_r, miss_nxt;
  logic [31:0]                         evict_r, evict_nxt;
  logic [MAX_WAYS-1:0]                 vld_r, vld_nxt;
  logic [MAX_WAYS-1:0]                 used_r, used_nxt;
  logic [HW-1:0]                       hand_r, hand_nxt;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tags_r, tags_nxt;
  logic [SW-1:0]                       set_r;
  logic [ADDR_WIDTH-1:0]               tag_r;
  logic [1:0]                          outcome_r, outcome_nxt;

  logic                  op_dbl;
  logic [SW-1:0]         op_set;
  logic [ADDR_WIDTH-1:0] op_tag;
  logic [5:0]            nways;
  logic [5:0]            hand_inc;
  logic [HW-1:0]         hand_wrap;
  logic [MAX_WAYS-1:0]   hit_vec;
  logic                  hit_any;
  logic [HW-1:0]         hit_idx;
  logic                  rd_en;
  logic                  clr_we;
  logic                  row_we;

  assign op_dbl = op_data[OP_W-1];
  assign op_set = op_data[ADDR_WIDTH +: SW];
  assign op_tag = op_data[ADDR_WIDTH-1:0];

  assign nways = (cfg.ways == 4'd0) ? 6'd1 :
                 (({2'b00, cfg.ways} > 6'(MAX_WAYS)) ? 6'(MAX_WAYS) : {2'b00, cfg.ways});
  assign hand_inc  = 6'(hand_r) + 6'd1;
  assign hand_wrap = (hand_inc == nways) ? '0 : HW'(hand_inc);

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_vec[w] = vld_r[w] && (tags_r[w] == tag_r) && (6'(w) < nways);
    end
    hit_any = 1'b0;
    hit_idx = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_any = 1'b1;
        hit_idx = HW'(w);
      end
    end
  end

  assign rd_en    = (state_r == ST_IDLE) && op_valid;
  assign op_pop   = rd_en;
  assign clr_we   = (state_r == ST_CLEAR);
  assign row_we   = (state_r == ST_WRITE) && !res_full;
  assign res_push = row_we;

  assign res_data.outcome     = outcome_r;
  assign res_data.last        = !dbl_r;
  assign res_data.hit_total   = hit_r;
  assign res_data.miss_total  = miss_r;
  assign res_data.evict_total = evict_r;

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    dbl_nxt     = dbl_r;
    hit_nxt     = hit_r;
    miss_nxt    = miss_r;
    evict_nxt   = evict_r;
    vld_nxt     = vld_r;
    used_nxt    = used_r;
    hand_nxt    = hand_r;
    tags_nxt    = tags_r;
    outcome_nxt = outcome_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (op_valid) begin
          dbl_nxt   = op_dbl;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (hit_any) begin
          used_nxt[hit_idx] = 1'b1;
          hit_nxt           = sacc_pkg::sat_inc(hit_r);
          outcome_nxt       = sacc_pkg::OUT_HIT;
          state_nxt         = ST_WRITE;
        end else begin
          miss_nxt = sacc_pkg::sat_inc(miss_r);
          if (6'(hand_r) >= nways) begin
            hand_nxt = '0;
          end
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (used_r[hand_r]) begin
          used_nxt[hand_r] = 1'b0;
          hand_nxt         = hand_wrap;
        end else begin
          if (vld_r[hand_r]) begin
            evict_nxt   = sacc_pkg::sat_inc(evict_r);
            outcome_nxt = sacc_pkg::OUT_EVICT;
          end else begin
            outcome_nxt = sacc_pkg::OUT_MISS;
          end
          used_nxt[hand_r] = 1'b1;
          vld_nxt[hand_r]  = 1'b1;
          tags_nxt[hand_r] = tag_r;
          hand_nxt         = hand_wrap;
          state_nxt        = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!res_full) begin
          if (dbl_r) begin
            dbl_nxt   = 1'b0;
            state_nxt = ST_LOOK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      dbl_r   <= 1'b0;
      hit_r   <= '0;
      miss_r  <= '0;
      evict_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      dbl_r   <= dbl_nxt;
      hit_r   <= hit_nxt;
      miss_r  <= miss_nxt;
      evict_r <= evict_nxt;
    end
  end

  always_ff @(posedge clk) begin
    outcome_r <= outcome_nxt;
    if (rd_en) begin
      vld_r  <= vld_mem[op_set];
      used_r <= used_mem[op_set];
      hand_r <= hand_mem[op_set];
      tags_r <= tag_mem[op_set];
      set_r  <= op_set;
      tag_r  <= op_tag;
    end else begin
      vld_r  <= vld_nxt;
      used_r <= used_nxt;
      hand_r <= hand_nxt;
      tags_r <= tags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      vld_mem[clr_r]  <= '0;
      used_mem[clr_r] <= '0;
      hand_mem[clr_r] <= '0;
    end else if (row_we) begin
      vld_mem[set_r]  <= vld_r;
      used_mem[set_r] <= used_r;
      hand_mem[set_r] <= hand_r;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      tag_mem[set_r] <= tags_r;
    end
  end

endmodule

// ----- hw/rtl/set_assoc_cache_clock_replace_core.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_clock_replace_core
// Tag store of a set-associative cache with clock (second-chance) replacement.
//
// Accesses enter through a queue port: in_data carries kind and address and
// is taken while push is high and full is low. Loads and stores produce one
// result beat, a modify produces two (the second marked last), and other
// kinds are taken and dropped. Results leave through a queue port: out_data
// is valid while empty is low and is taken when pop is high.
// A lookup reads its set row into registers and compares all ways in the
// next cycle. A hit then writes the row back and delivers. A miss walks
// the clock hand one way per cycle, clearing each used line's use bit,
// then fills the first line from the hand with a clear use bit, writes back
// and delivers. The engine takes no new lookup until this one is delivered.
// The cfg port (index, data) is always ready and should be written only
// while no access is in flight. After reset the row memory is cleared one
// set per cycle, all 2**MAX_SET_BITS sets, during which full stays high
// once the small lookup queue fills. When pop is held low, finished results
// wait in a two-beat output queue and the engine stalls behind it.
// ----------------------------------------------------------------------------
module set_assoc_cache_clock_replace_core #(
  parameter int MAX_SET_BITS = 5,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sacc_pkg::in_t  in_data,
  output logic           full,
  input  logic           pop,
  output sacc_pkg::out_t out_data,
  output logic           empty,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [5:0]     cfg_data
);

  localparam int SW        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int OP_W      = 1 + SW + ADDR_WIDTH;
  localparam int RES_DEPTH = 2;

  sacc_pkg::cfg_t             cfg_r;
  logic                       op_valid;
  logic [OP_W-1:0]            op_data;
  logic                       op_pop;
  logic                       res_full;
  logic                       res_push;
  sacc_pkg::out_t             res_data;
  logic [$bits(sacc_pkg::out_t)-1:0] res_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_bits   <= 3'd0;
      cfg_r.block_bits <= 6'd4;
      cfg_r.ways       <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sacc_pkg::CFG_SET_BITS:   cfg_r.set_bits   <= cfg_data[2:0];
        sacc_pkg::CFG_BLOCK_BITS: cfg_r.block_bits <= cfg_data;
        sacc_pkg::CFG_WAYS:       cfg_r.ways       <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  sacc_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .op_valid (op_valid),
    .op_data  (op_data),
    .op_pop   (op_pop)
  );

  sacc_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .op_valid (op_valid),
    .op_data  (op_data),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  sacc_fifo #(
    .WIDTH ($bits(sacc_pkg::out_t)),
    .DEPTH (RES_DEPTH)
  ) u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_q),
    .empty   (empty)
  );

  assign out_data = res_q;

endmodule

// ----- hw/rtl/sacc_check.sv -----
// ----------------------------------------------------------------------------
// sacc_check
// Port-level checks of the cache tag store, bound to the top level.
// ----------------------------------------------------------------------------
module sacc_check (
  input logic           clk,
  input logic           rst_n,
  input logic           pop,
  input logic           empty,
  input sacc_pkg::out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.outcome == sacc_pkg::OUT_HIT ||
                out_data.outcome == sacc_pkg::OUT_MISS ||
                out_data.outcome == sacc_pkg::OUT_EVICT))
    else $error("undefined outcome code");

  a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.evict_total <= out_data.miss_total))
    else $error("eviction total exceeds miss total");

  a_total_counted: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_data.outcome == sacc_pkg::OUT_HIT && out_data.hit_total != 32'd0) ||
                (out_data.outcome != sacc_pkg::OUT_HIT && out_data.miss_total != 32'd0)))
    else $error("result not reflected in its running total");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind set_assoc_cache_clock_replace_core sacc_check u_sacc_check (
  .clk      (clk),
  .rst_n    (rst_n),
  .pop      (pop),
  .empty    (empty),
  .out_data (out_data)
);

// ----- test/tb_set_assoc_cache_clock_replace_core.sv -----
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_clock_replace_core
// Self-checking testbench of the clock-replacement cache tag store.
//
// A local model of the tag store, its use bits, the per-set clock hands and
// the running totals predicts every result beat of each accepted access.
// Directed accesses cover the reset configuration, the hand walk with
// wrap-around, clamped register values and addresses with no tag bits left.
// Random phases then mix working-set accesses with noise under several
// configurations, with idle gaps on the sender and stalls on the receiver.
// A long receiver hold-off fills the block, and a drain pause follows.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_clock_replace_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SET_BITS = 5;
  localparam int MAX_WAYS     = 8;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int IDLE_PAUSE   = 40;
  localparam int PHASE_ITEMS  = 150;

  logic           clk;
  logic           rst_n;
  logic           push;
  sacc_pkg::in_t  in_data;
  logic           full;
  logic           pop;
  sacc_pkg::out_t out_data;
  logic           empty;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [1:0]     cfg_index;
  logic [5:0]     cfg_data;

  set_assoc_cache_clock_replace_core #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS),
    .ADDR_WIDTH  (64)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .pop      (pop),
    .out_data (out_data),
    .empty    (empty),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow of the tag store and its registers.
  bit          line_ok   [NUM_SETS][MAX_WAYS];
  bit          line_ref  [NUM_SETS][MAX_WAYS];
  logic [63:0] line_tg   [NUM_SETS][MAX_WAYS];
  int unsigned hand_pos  [NUM_SETS];
  logic [31:0] hit_cnt;
  logic [31:0] miss_cnt;
  logic [31:0] evict_cnt;
  logic [2:0]  set_bits_reg;
  logic [5:0]  block_bits_reg;
  logic [3:0]  ways_reg;

  sacc_pkg::out_t pending_beats[$];
  logic [63:0]    addr_pool[12];

  int          fail_count;
  int          beats_checked;
  int          hits_seen;
  int          evicts_seen;
  int          items_sent;
  int unsigned cycle_count;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  bit          hold_start;
  int unsigned hold_left;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int unsigned eff_set_bits();
    return (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_reg;
  endfunction

  function automatic int unsigned eff_ways();
    if (ways_reg == 0) return 1;
    return (ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg;
  endfunction

  function automatic logic [1:0] probe_set(int unsigned s, logic [63:0] tg,
                                           int unsigned nw);
    int unsigned h;
    logic [1:0]  res;
    for (int unsigned w = 0; w < nw; w++) begin
      if (line_ok[s][w] && line_tg[s][w] == tg) begin
        line_ref[s][w] = 1'b1;
        hit_cnt = bump(hit_cnt);
        return sacc_pkg::OUT_HIT;
      end
    end
    miss_cnt = bump(miss_cnt);
    h = hand_pos[s];
    if (h >= nw) h = 0;
    while (line_ref[s][h]) begin
      line_ref[s][h] = 1'b0;
      h = (h + 1) % nw;
    end
    res = sacc_pkg::OUT_MISS;
    if (line_ok[s][h]) begin
      evict_cnt = bump(evict_cnt);
      res = sacc_pkg::OUT_EVICT;
    end
    line_ref[s][h] = 1'b1;
    line_ok[s][h]  = 1'b1;
    line_tg[s][h]  = tg;
    hand_pos[s]    = (h + 1) % nw;
    return res;
  endfunction

  function automatic void predict_access(sacc_pkg::in_t beat);
    int unsigned    sb;
    int unsigned    nw;
    int unsigned    shift;
    int unsigned    s;
    int unsigned    count;
    logic [63:0]    tg;
    sacc_pkg::out_t r;
    sb    = eff_set_bits();
    nw    = eff_ways();
    shift = block_bits_reg + sb;
    s     = int'((beat.address >> block_bits_reg) & ((64'd1 << sb) - 64'd1));
    tg    = (shift >= 64) ? 64'd0 : (beat.address >> shift);
    if (beat.kind == sacc_pkg::KIND_OTHER) return;
    count = (beat.kind == sacc_pkg::KIND_MODIFY) ? 2 : 1;
    for (int unsigned k = 0; k < count; k++) begin
      r.outcome     = probe_set(s, tg, nw);
      r.last        = (k == count - 1);
      r.hit_total   = hit_cnt;
      r.miss_total  = miss_cnt;
      r.evict_total = evict_cnt;
      pending_beats.push_back(r);
    end
  endfunction

  function automatic logic [63:0] make_address(logic [63:0] tg, int unsigned s,
                                               logic [63:0] offset);
    int unsigned sb;
    int unsigned shift;
    logic [63:0] a;
    sb    = eff_set_bits();
    shift = block_bits_reg + sb;
    a = (shift >= 64) ? 64'd0 : (tg << shift);
    a = a | ((64'(s) & ((64'd1 << sb) - 64'd1)) << block_bits_reg);
    a = a | (offset & ((64'd1 << block_bits_reg) - 64'd1));
    return a;
  endfunction

  always @(posedge clk) begin
    sacc_pkg::out_t want;
    if (rst_n && pop && !empty) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: outcome %0d", out_data.outcome);
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        if (out_data.outcome == sacc_pkg::OUT_HIT) hits_seen++;
        if (out_data.outcome == sacc_pkg::OUT_EVICT) evicts_seen++;
        if (out_data.outcome !== want.outcome) begin
          $error("outcome: expected %0d, actual %0d", want.outcome, out_data.outcome);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_data.last);
          fail_count++;
        end
        if (out_data.hit_total !== want.hit_total) begin
          $error("hit_total: expected %0d, actual %0d", want.hit_total,
                 out_data.hit_total);
          fail_count++;
        end
        if (out_data.miss_total !== want.miss_total) begin
          $error("miss_total: expected %0d, actual %0d", want.miss_total,
                 out_data.miss_total);
          fail_count++;
        end
        if (out_data.evict_total !== want.evict_total) begin
          $error("evict_total: expected %0d, actual %0d", want.evict_total,
                 out_data.evict_total);
          fail_count++;
        end
      end
    end
  end

  initial begin
    pop       = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = 400;
      end
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_access(logic [1:0] kind, logic [63:0] addr);
    sacc_pkg::in_t beat;
    beat.kind    = kind;
    beat.address = addr;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push    = 1'b1;
    in_data = beat;
    do @(posedge clk); while (full);
    predict_access(beat);
    if (kind != sacc_pkg::KIND_OTHER) items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] data);
    wait_drained();
    repeat (IDLE_PAUSE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sacc_pkg::CFG_SET_BITS:   set_bits_reg   = data[2:0];
      sacc_pkg::CFG_BLOCK_BITS: block_bits_reg = data;
      sacc_pkg::CFG_WAYS:       ways_reg       = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_reset_config();
    send_access(sacc_pkg::KIND_LOAD, 64'h0);
    send_access(sacc_pkg::KIND_LOAD, 64'hF);
    send_access(sacc_pkg::KIND_STORE, 64'h10);
    send_access(sacc_pkg::KIND_MODIFY, 64'h20);
    send_access(sacc_pkg::KIND_OTHER, 64'h20);
    send_access(sacc_pkg::KIND_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(sacc_pkg::KIND_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_clock_walk();
    write_reg(sacc_pkg::CFG_SET_BITS, 6'd7);
    write_reg(sacc_pkg::CFG_BLOCK_BITS, 6'd0);
    write_reg(sacc_pkg::CFG_WAYS, 6'd15);
    for (int t = 1; t <= 9; t++) send_access(sacc_pkg::KIND_LOAD, 64'(t) << 5);
    send_access(sacc_pkg::KIND_STORE, 64'd2 << 5);
    send_access(sacc_pkg::KIND_MODIFY, 64'd10 << 5);
    // The hand now points past the lowered way count.
    write_reg(sacc_pkg::CFG_WAYS, 6'd3);
    send_access(sacc_pkg::KIND_LOAD, 64'd20 << 5);
    write_reg(sacc_pkg::CFG_WAYS, 6'd0);
    send_access(sacc_pkg::KIND_LOAD, 64'd21 << 5);
  endtask

  task automatic test_wide_block();
    write_reg(sacc_pkg::CFG_SET_BITS, 6'd5);
    write_reg(sacc_pkg::CFG_BLOCK_BITS, 6'd63);
    write_reg(sacc_pkg::CFG_WAYS, 6'd8);
    send_access(sacc_pkg::KIND_LOAD, 64'h8000_0000_0000_0000);
    send_access(sacc_pkg::KIND_STORE, 64'h7FFF_FFFF_FFFF_FFFF);
    send_access(sacc_pkg::KIND_MODIFY, 64'hFFFF_0000_0000_1234);
  endtask

  task automatic random_config(int unsigned pick);
    logic [2:0] sb;
    logic [5:0] bb;
    logic [3:0] nw;
    case (pick)
      0: begin sb = 3'd0; bb = 6'd0;  nw = 4'd1; end
      1: begin sb = 3'd5; bb = 6'd58; nw = 4'd8; end
      default: begin
        sb = 3'($urandom_range(0, 7));
        bb = ($urandom_range(3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 12));
        nw = 4'($urandom_range(0, 15));
      end
    endcase
    write_reg(sacc_pkg::CFG_SET_BITS, {3'($urandom_range(0, 7)), sb});
    write_reg(sacc_pkg::CFG_BLOCK_BITS, bb);
    write_reg(sacc_pkg::CFG_WAYS, {2'($urandom_range(0, 3)), nw});
    for (int i = 0; i < 12; i++) begin
      addr_pool[i] = make_address(64'($urandom_range(0, 2 * MAX_WAYS)),
                                  $urandom_range(0, 3), {$urandom, $urandom});
    end
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned pick);
    int unsigned   done;
    int unsigned   roll;
    logic [1:0]    kind;
    logic [63:0]   addr;
    random_config(pick);
    tx_idle_pct  = idle;
    rx_stall_pct = stall;
    done = 0;
    while (done < PHASE_ITEMS) begin
      roll = $urandom_range(99);
      kind = 2'($urandom_range(0, 2));
      if (roll < 10) begin
        kind = sacc_pkg::KIND_OTHER;
        addr = {$urandom, $urandom};
      end else if (roll < 25) begin
        addr = {$urandom, $urandom};
      end else begin
        addr = addr_pool[$urandom_range(0, 11)] ^ 64'($urandom_range(0, 1) << block_bits_reg >> 1);
      end
      send_access(kind, addr);
      if (kind != sacc_pkg::KIND_OTHER) done++;
    end
  endtask

  task automatic test_random_phases();
    run_phase(0, 0, 0);
    run_phase(0, 0, 2);
    run_phase(66, 0, 1);
    run_phase(66, 0, 2);
    run_phase(0, 66, 2);
    run_phase(0, 66, 2);
    run_phase(27, 27, 2);
    run_phase(27, 27, 2);
  endtask

  task automatic test_backpressure();
    write_reg(sacc_pkg::CFG_SET_BITS, 6'd2);
    write_reg(sacc_pkg::CFG_BLOCK_BITS, 6'd4);
    write_reg(sacc_pkg::CFG_WAYS, 6'd4);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    @(posedge clk);
    hold_start = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_access(2'($urandom_range(0, 2)), 64'($urandom_range(0, 255)) << 4);
    end
    // Let the block run dry before offering more.
    wait_drained();
    for (int i = 0; i < 10; i++) begin
      send_access(2'($urandom_range(0, 3)), 64'($urandom_range(0, 255)) << 4);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    push           = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = sacc_pkg::CFG_SET_BITS;
    cfg_data       = '0;
    hold_start     = 1'b0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    fail_count     = 0;
    beats_checked  = 0;
    hits_seen      = 0;
    evicts_seen    = 0;
    items_sent     = 0;
    cycle_count    = 0;
    hit_cnt        = '0;
    miss_cnt       = '0;
    evict_cnt      = '0;
    set_bits_reg   = 3'd0;
    block_bits_reg = 6'd4;
    ways_reg       = 4'd1;
    for (int s = 0; s < NUM_SETS; s++) begin
      hand_pos[s] = 0;
      for (int w = 0; w < MAX_WAYS; w++) begin
        line_ok[s][w]  = 1'b0;
        line_ref[s][w] = 1'b0;
        line_tg[s][w]  = '0;
      end
    end
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    // Give the row clearing pass time before the first access.
    repeat (IDLE_PAUSE) @(negedge clk);

    test_reset_config();
    test_clock_walk();
    test_wide_block();
    test_random_phases();
    test_backpressure();

    wait_drained();
    repeat (IDLE_PAUSE) @(negedge clk);
    $display("covered %0d accesses and %0d result beats (%0d hits, %0d evictions)",
             items_sent, beats_checked, hits_seen, evicts_seen);
    $display("across reset, clamped and random configurations with idle, stall and hold-off");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
